[design/ppt_pkg.sv]
package ppt_pkg;

	localparam int RING_DEPTH  = 256;
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int CNT_W       = PTR_W + 1;
	localparam int SWEEP_SLOTS = 8;
	localparam int SWP_W       = $clog2(SWEEP_SLOTS);

	localparam logic [15:0] FULL_CIRCLE = 16'd36000;
	localparam logic [15:0] HALF_CIRCLE = 16'd18000;

	// input flag bits
	localparam int FL_ACTIVE   = 0;
	localparam int FL_AZ_POINT = 1;
	localparam int FL_AZ_SWEEP = 2;
	localparam int FL_AZ_DONE  = 3;
	localparam int FL_EL_POINT = 4;
	localparam int FL_EL_SWEEP = 5;
	localparam int FL_EL_DONE  = 6;
	localparam logic [6:0] FL_DONE_MASK = 7'h48;

	// marker bits
	localparam int MK_MIDDLE = 0;
	localparam int MK_BEGIN  = 1;
	localparam int MK_END    = 2;
	localparam int MK_PPI    = 3;
	localparam int MK_RHI    = 4;
	localparam int MK_POINT  = 5;
	localparam logic [5:0] MK_RESET = 6'h04;

	// status codes
	localparam logic ST_TAGGED      = 1'b0;
	localparam logic ST_NO_POSITION = 1'b1;

	// one ring entry
	typedef struct packed {
		logic [47:0] stamp;
		logic [15:0] az;
		logic [15:0] el;
		logic [15:0] az_rate;
		logic [15:0] el_rate;
		logic [15:0] raw_az;
		logic [15:0] raw_el;
		logic [6:0]  flags;
		logic [15:0] tgt_el;
		logic [15:0] tgt_az;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// reduce a 16-bit angle below one full circle
	function automatic logic [15:0] mod_circle(input logic [15:0] a);
		logic [15:0] r;
		begin
			r = (a >= FULL_CIRCLE) ? 16'(a - FULL_CIRCLE) : a;
			return r;
		end
	endfunction

	// ring pointer step forward and back
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		begin
			r = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
			return r;
		end
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		begin
			r = (p == '0) ? PTR_W'(RING_DEPTH - 1) : PTR_W'(p - 1'b1);
			return r;
		end
	endfunction

	// shortest signed difference b - a, folded into half a circle
	function automatic logic signed [15:0] fold_diff(input logic [15:0] a,
		input logic [15:0] b);
		logic signed [16:0] d;
		begin
			d = $signed({1'b0, b}) - $signed({1'b0, a});
			if (d > $signed({1'b0, HALF_CIRCLE}))
				d = d - $signed({1'b0, FULL_CIRCLE});
			else if (d < -$signed({1'b0, HALF_CIRCLE}))
				d = d + $signed({1'b0, FULL_CIRCLE});
			return d[15:0];
		end
	endfunction

	// add rounded Q16 product to base angle and wrap
	function automatic logic [15:0] wrap_angle(input logic [15:0] a,
		input logic signed [33:0] prod);
		logic signed [33:0] s;
		logic signed [17:0] q;
		logic signed [18:0] x;
		begin
			s = prod + 34'sd32768;
			q = s[33:16];
			x = $signed({3'b000, a}) + $signed({q[17], q});
			if (x < 19'sd0)
				x = x + $signed({3'b000, FULL_CIRCLE});
			else if (x >= $signed({3'b000, FULL_CIRCLE}))
				x = x - $signed({3'b000, FULL_CIRCLE});
			return x[15:0];
		end
	endfunction

endpackage

[design/ppt_ram.sv]
module ppt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

[design/pulse_position_tagger_core.sv]
// a pulse request walks the ring, reads the earlier sample, runs the serial divider
//   when the two samples need a real interpolation division, then multiplies, adds
//   and registers the result; with no position found it goes straight to the output
// throughput: one request at a time; a store request is written while idle, a pulse
//   occupies the block for the ring walk (one ring read per cycle), the serial divider and the output
// reset: arst_n clears pointers, fill count, sweep counter and handshake state;
//   the previous marker resets to sweep end; ring contents stay undefined
module pulse_position_tagger_core import ppt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [47:0]       stamp_us,
	input  logic [15:0]       azimuth_cdeg,
	input  logic [15:0]       elevation_cdeg,
	input  logic signed [15:0] azimuth_rate,
	input  logic signed [15:0] elevation_rate,
	input  logic [15:0]       raw_azimuth,
	input  logic [15:0]       raw_elevation,
	input  logic [6:0]        flags,
	input  logic [15:0]       target_elevation,
	input  logic [15:0]       target_azimuth,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [15:0]       pulse_azimuth,
	output logic [15:0]       pulse_elevation,
	output logic signed [15:0] pulse_az_rate,
	output logic signed [15:0] pulse_el_rate,
	output logic [15:0]       pulse_raw_az,
	output logic [15:0]       pulse_raw_el,
	output logic [5:0]        marker,
	output logic [2:0]        sweep_number,
	output logic [15:0]       sweep_elevation,
	output logic [15:0]       sweep_azimuth
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_GB   = 3'd2;
	localparam logic [2:0] S_ALP  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_ADD  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]       state_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] stored_q;
	logic [PTR_W-1:0] search_q;
	logic [PTR_W-1:0] p_q;
	logic [CNT_W-1:0] steps_q;
	logic [6:0]       ends_q;
	logic [5:0]       prev_mk_q;
	logic [SWP_W-1:0] sweep_q;
	logic [3:0]       div_cnt_q;

	logic [47:0]       t_q;
	entry_t            aft_q;
	entry_t            bef_q;
	logic [47:0]       rem_q;
	logic [47:0]       den_q;
	logic [15:0]       quo_q;
	logic [16:0]       alpha_q;
	logic signed [33:0] prod_az_q;
	logic signed [33:0] prod_el_q;

	logic              res_status_q;
	logic [15:0]       res_az_q;
	logic [15:0]       res_el_q;
	logic [15:0]       res_az_rate_q;
	logic [15:0]       res_el_rate_q;
	logic [15:0]       res_raw_az_q;
	logic [15:0]       res_raw_el_q;
	logic [5:0]        res_mk_q;
	logic [2:0]        res_sweep_q;
	logic [15:0]       res_tgt_el_q;
	logic [15:0]       res_tgt_az_q;

	logic              in_acc;
	logic              store_req;
	logic              pulse_req;
	logic              out_free;
	logic [PTR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t            wr_entry;
	entry_t            cur;
	logic              wr_p;
	logic              wr_b;
	logic              cont;
	logic              fail;
	logic              more_steps;
	logic [48:0]       div_sh;
	logic              div_ge;
	logic [15:0]       quo_next;
	logic [5:0]        mk;
	logic [SWP_W-1:0]  sweep_next;
	logic [6:0]        fl_b;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign store_req = in_acc && !op;
	assign pulse_req = in_acc && op;
	assign out_free  = !out_valid || !out_stall;

	// entry built from a store request
	always_comb begin
		wr_entry.stamp   = stamp_us;
		wr_entry.az      = mod_circle(azimuth_cdeg);
		wr_entry.el      = mod_circle(elevation_cdeg);
		wr_entry.az_rate = azimuth_rate;
		wr_entry.el_rate = elevation_rate;
		wr_entry.raw_az  = raw_azimuth;
		wr_entry.raw_el  = raw_elevation;
		wr_entry.flags   = flags;
		wr_entry.tgt_el  = mod_circle(target_elevation);
		wr_entry.tgt_az  = mod_circle(target_azimuth);
	end

	// ring walk decision
	always_comb begin
		cur        = entry_t'(rd_data);
		more_steps = (steps_q < CNT_W'(RING_DEPTH));
		wr_p       = (stored_q >= CNT_W'(RING_DEPTH)) || ({1'b0, p_q} < stored_q);
		wr_b       = (stored_q >= CNT_W'(RING_DEPTH)) ||
		             ({1'b0, ptr_prev(p_q)} < stored_q);
		cont       = more_steps && wr_p && (cur.stamp <= t_q);
		fail       = !more_steps || !wr_p || !wr_b;
	end

	// read address: search start, speculative next step, or earlier sample
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = search_q;
			S_CHK:   rd_addr = cont ? ptr_next(p_q) : ptr_prev(p_q);
			default: rd_addr = p_q;
		endcase
	end

	ppt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (store_req),
		.wr_addr (wp_q),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one restoring division step
	always_comb begin
		div_sh   = {rem_q, 1'b0};
		div_ge   = (div_sh >= {1'b0, den_q});
		quo_next = {quo_q[14:0], div_ge};
	end

	// sweep marker from earlier sample flags, step count and previous marker
	always_comb begin
		fl_b = bef_q.flags;
		mk   = '0;
		mk[MK_MIDDLE] = fl_b[FL_ACTIVE];
		if (fl_b[FL_EL_POINT] && fl_b[FL_AZ_SWEEP])
			mk[MK_PPI] = 1'b1;
		else if (fl_b[FL_AZ_POINT] && fl_b[FL_EL_SWEEP])
			mk[MK_RHI] = 1'b1;
		else if (fl_b[FL_AZ_POINT] && fl_b[FL_EL_POINT])
			mk[MK_POINT] = 1'b1;
		if ((steps_q == CNT_W'(2)) && |(fl_b & FL_DONE_MASK))
			mk[MK_END] = 1'b1;
		else if ((steps_q > CNT_W'(2)) && |ends_q && !prev_mk_q[MK_END])
			mk[MK_END] = 1'b1;
		if (!prev_mk_q[MK_MIDDLE] && mk[MK_MIDDLE])
			mk[MK_BEGIN] = 1'b1;
		if (prev_mk_q[MK_MIDDLE] && !mk[MK_MIDDLE])
			mk[MK_END] = 1'b1;
		if (prev_mk_q[MK_END] && mk[MK_MIDDLE])
			mk[MK_BEGIN] = 1'b1;
		sweep_next = sweep_q;
		if (mk[MK_BEGIN])
			sweep_next = (sweep_q == SWP_W'(SWEEP_SLOTS - 1)) ? '0 : SWP_W'(sweep_q + 1'b1);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			stored_q  <= '0;
			search_q  <= '0;
			prev_mk_q <= MK_RESET;
			sweep_q   <= '0;
			out_valid <= 1'b0;
			p_q       <= '0;
			steps_q   <= '0;
			div_cnt_q <= '0;
		end else begin
			if ((state_q == S_OUT) && out_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (store_req) begin
						wp_q <= ptr_next(wp_q);
						if (stored_q < CNT_W'(RING_DEPTH))
							stored_q <= CNT_W'(stored_q + 1'b1);
					end
					if (pulse_req) begin
						p_q     <= search_q;
						steps_q <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cont) begin
						p_q     <= ptr_next(p_q);
						steps_q <= CNT_W'(steps_q + 1'b1);
					end else if (fail) begin
						search_q <= p_q;
						state_q  <= S_OUT;
					end else begin
						search_q <= ptr_prev(p_q);
						state_q  <= S_GB;
					end
				end
				S_GB:  state_q <= S_ALP;
				S_ALP: begin
					div_cnt_q <= '0;
					if ((aft_q.stamp <= bef_q.stamp) || (t_q <= bef_q.stamp) ||
					    (48'(t_q - bef_q.stamp) >= 48'(aft_q.stamp - bef_q.stamp)))
						state_q <= S_MUL;
					else
						state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= 4'(div_cnt_q + 1'b1);
					if (div_cnt_q == 4'd15)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					prev_mk_q <= mk;
					sweep_q   <= sweep_next;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q    <= stamp_us;
				ends_q <= '0;
			end
			S_CHK: begin
				if (cont) begin
					ends_q <= ends_q | (cur.flags & FL_DONE_MASK);
				end else begin
					aft_q         <= cur;
					res_status_q  <= ST_NO_POSITION;
					res_az_q      <= '0;
					res_el_q      <= '0;
					res_az_rate_q <= '0;
					res_el_rate_q <= '0;
					res_raw_az_q  <= '0;
					res_raw_el_q  <= '0;
					res_mk_q      <= '0;
					res_sweep_q   <= '0;
					res_tgt_el_q  <= '0;
					res_tgt_az_q  <= '0;
				end
			end
			S_GB: bef_q <= entry_t'(rd_data);
			S_ALP: begin
				rem_q <= 48'(t_q - bef_q.stamp);
				den_q <= 48'(aft_q.stamp - bef_q.stamp);
				quo_q <= '0;
				if ((aft_q.stamp <= bef_q.stamp) || (t_q <= bef_q.stamp))
					alpha_q <= '0;
				else
					alpha_q <= 17'h10000;
			end
			S_DIV: begin
				rem_q <= div_ge ? 48'(div_sh - {1'b0, den_q}) : 48'(div_sh);
				quo_q <= quo_next;
				if (div_cnt_q == 4'd15)
					alpha_q <= {1'b0, quo_next};
			end
			S_MUL: begin
				prod_az_q <= fold_diff(bef_q.az, aft_q.az) * $signed({1'b0, alpha_q});
				prod_el_q <= fold_diff(bef_q.el, aft_q.el) * $signed({1'b0, alpha_q});
			end
			S_ADD: begin
				res_status_q  <= ST_TAGGED;
				res_az_q      <= wrap_angle(bef_q.az, prod_az_q);
				res_el_q      <= wrap_angle(bef_q.el, prod_el_q);
				res_az_rate_q <= bef_q.az_rate;
				res_el_rate_q <= bef_q.el_rate;
				res_raw_az_q  <= bef_q.raw_az;
				res_raw_el_q  <= bef_q.raw_el;
				res_mk_q      <= mk;
				res_sweep_q   <= 3'(sweep_next);
				res_tgt_el_q  <= mk[MK_BEGIN] ? aft_q.tgt_el : '0;
				res_tgt_az_q  <= mk[MK_BEGIN] ? aft_q.tgt_az : '0;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			status          <= res_status_q;
			pulse_azimuth   <= res_az_q;
			pulse_elevation <= res_el_q;
			pulse_az_rate   <= res_az_rate_q;
			pulse_el_rate   <= res_el_rate_q;
			pulse_raw_az    <= res_raw_az_q;
			pulse_raw_el    <= res_raw_el_q;
			marker          <= res_mk_q;
			sweep_number    <= res_sweep_q;
			sweep_elevation <= res_tgt_el_q;
			sweep_azimuth   <= res_tgt_az_q;
		end
	end

endmodule

[design/ppt_checker.sv]
module ppt_checker import ppt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        status,
	input logic [15:0] pulse_azimuth,
	input logic [15:0] pulse_elevation,
	input logic [5:0]  marker,
	input logic [15:0] sweep_azimuth
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its azimuth and marker
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pulse_azimuth) && $stable(marker))
		else $error("result changed while stalled");

	// interpolated angles stay inside one circle
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pulse_azimuth < FULL_CIRCLE) && (pulse_elevation < FULL_CIRCLE))
		else $error("angle out of range");

	// no position gives an all-zero result
	a_no_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_POSITION) |->
		(marker == 6'd0) && (pulse_azimuth == 16'd0) && (sweep_azimuth == 16'd0))
		else $error("no position result not cleared");

endmodule

bind pulse_position_tagger_core ppt_checker u_ppt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.pulse_azimuth   (pulse_azimuth),
	.pulse_elevation (pulse_elevation),
	.marker          (marker),
	.sweep_azimuth   (sweep_azimuth)
);

[bench/pulse_position_tagger_core_tb.sv]
module pulse_position_tagger_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 400;

	// one tagged pulse as seen on the result port
	typedef struct {
		logic              status;
		logic [15:0]       az;
		logic [15:0]       el;
		logic signed [15:0] az_rate;
		logic signed [15:0] el_rate;
		logic [15:0]       raw_az;
		logic [15:0]       raw_el;
		logic [5:0]        marker;
		logic [2:0]        sweep_num;
		logic [15:0]       sweep_el;
		logic [15:0]       sweep_az;
	} pulse_tag_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              op = 1'b0;
	logic [47:0]       stamp_us = '0;
	logic [15:0]       azimuth_cdeg = '0;
	logic [15:0]       elevation_cdeg = '0;
	logic signed [15:0] azimuth_rate = '0;
	logic signed [15:0] elevation_rate = '0;
	logic [15:0]       raw_azimuth = '0;
	logic [15:0]       raw_elevation = '0;
	logic [6:0]        flags = '0;
	logic [15:0]       target_elevation = '0;
	logic [15:0]       target_azimuth = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              status;
	logic [15:0]       pulse_azimuth;
	logic [15:0]       pulse_elevation;
	logic signed [15:0] pulse_az_rate;
	logic signed [15:0] pulse_el_rate;
	logic [15:0]       pulse_raw_az;
	logic [15:0]       pulse_raw_el;
	logic [5:0]        marker;
	logic [2:0]        sweep_number;
	logic [15:0]       sweep_elevation;
	logic [15:0]       sweep_azimuth;

	// predictor state
	entry_t      pos_ring [RING_DEPTH];
	int          ring_wr;
	int          ring_fill;
	int          search_at;
	logic [5:0]  last_marker;
	int          sweep_ctr;
	pulse_tag_t  due_tags [$];

	int          mismatches = 0;
	int          idle_in_pct = 0;
	int          stall_out_pct = 0;
	int          idle_cycles = 0;
	int          pulses_seen = 0;
	int          lost_pulses = 0;
	int          sweep_begins = 0;
	longint unsigned now_us;
	longint unsigned prev_us;

	pulse_position_tagger_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .stamp_us(stamp_us),
		.azimuth_cdeg(azimuth_cdeg), .elevation_cdeg(elevation_cdeg),
		.azimuth_rate(azimuth_rate), .elevation_rate(elevation_rate),
		.raw_azimuth(raw_azimuth), .raw_elevation(raw_elevation),
		.flags(flags), .target_elevation(target_elevation), .target_azimuth(target_azimuth),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pulse_azimuth(pulse_azimuth), .pulse_elevation(pulse_elevation),
		.pulse_az_rate(pulse_az_rate), .pulse_el_rate(pulse_el_rate),
		.pulse_raw_az(pulse_raw_az), .pulse_raw_el(pulse_raw_el),
		.marker(marker), .sweep_number(sweep_number),
		.sweep_elevation(sweep_elevation), .sweep_azimuth(sweep_azimuth)
	);

	always #5 clk = ~clk;

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_out_pct);
	end

	function automatic logic [15:0] reduce_circle(input logic [15:0] a);
		return (a >= 16'd36000) ? 16'(a - 16'd36000) : a;
	endfunction

	function automatic bit slot_written(input int p);
		return ring_fill >= RING_DEPTH || p < ring_fill;
	endfunction

	// blend two angles by a Q16 fraction along the short way round
	function automatic logic [15:0] blend_angle(input logic [15:0] a, input logic [15:0] b,
		input longint alpha);
		longint d;
		longint x;
		d = longint'(b) - longint'(a);
		if (d > 18000)
			d = d - 36000;
		else if (d < -18000)
			d = d + 36000;
		x = longint'(a) + ((d * alpha + 32768) >>> 16);
		while (x < 0)
			x = x + 36000;
		while (x >= 36000)
			x = x - 36000;
		return 16'(x);
	endfunction

	// update the position ring with an accepted sample
	task automatic store_position(input logic [47:0] st, input logic [15:0] az, el,
		input logic [15:0] ar, er, ra, re, input logic [6:0] fl, input logic [15:0] te, ta);
		entry_t e;
		e.stamp = st;
		e.az = reduce_circle(az);
		e.el = reduce_circle(el);
		e.az_rate = ar;
		e.el_rate = er;
		e.raw_az = ra;
		e.raw_el = re;
		e.flags = fl;
		e.tgt_el = reduce_circle(te);
		e.tgt_az = reduce_circle(ta);
		pos_ring[ring_wr] = e;
		ring_wr = (ring_wr + 1) % RING_DEPTH;
		if (ring_fill < RING_DEPTH)
			ring_fill++;
	endtask

	// walk the ring for a pulse and queue the expected tag
	task automatic compute_pulse_tag(input logic [47:0] t);
		pulse_tag_t r;
		int p;
		int b;
		int steps;
		logic [6:0] ends;
		logic [6:0] fl;
		logic [5:0] m;
		longint unsigned tb;
		longint unsigned ta;
		longint alpha;
		r = '{default: '0};
		r.status = ST_NO_POSITION;
		p = search_at;
		steps = 0;
		ends = '0;
		while (steps < RING_DEPTH && slot_written(p) && pos_ring[p].stamp <= t) begin
			ends |= pos_ring[p].flags & FL_DONE_MASK;
			p = (p + 1) % RING_DEPTH;
			steps++;
		end
		search_at = p;
		b = (p + RING_DEPTH - 1) % RING_DEPTH;
		pulses_seen++;
		if (steps >= RING_DEPTH || !slot_written(p) || !slot_written(b)) begin
			lost_pulses++;
			due_tags.push_back(r);
			return;
		end
		search_at = b;
		tb = pos_ring[b].stamp;
		ta = pos_ring[p].stamp;
		if (ta <= tb || t <= tb)
			alpha = 0;
		else if (t - tb >= ta - tb)
			alpha = 65536;
		else
			alpha = longint'(((64'(t) - tb) << 16) / (ta - tb));
		r.status = ST_TAGGED;
		r.az = blend_angle(pos_ring[b].az, pos_ring[p].az, alpha);
		r.el = blend_angle(pos_ring[b].el, pos_ring[p].el, alpha);
		r.az_rate = pos_ring[b].az_rate;
		r.el_rate = pos_ring[b].el_rate;
		r.raw_az = pos_ring[b].raw_az;
		r.raw_el = pos_ring[b].raw_el;
		// sweep marker from the earlier sample, step count and previous marker
		fl = pos_ring[b].flags;
		m = '0;
		if (fl[FL_ACTIVE])
			m[MK_MIDDLE] = 1'b1;
		if (fl[FL_EL_POINT] && fl[FL_AZ_SWEEP])
			m[MK_PPI] = 1'b1;
		else if (fl[FL_AZ_POINT] && fl[FL_EL_SWEEP])
			m[MK_RHI] = 1'b1;
		else if (fl[FL_AZ_POINT] && fl[FL_EL_POINT])
			m[MK_POINT] = 1'b1;
		if (steps == 2 && (fl & FL_DONE_MASK) != 0)
			m[MK_END] = 1'b1;
		else if (steps > 2 && ends != 0 && !last_marker[MK_END])
			m[MK_END] = 1'b1;
		if (!last_marker[MK_MIDDLE] && m[MK_MIDDLE])
			m[MK_BEGIN] = 1'b1;
		if (last_marker[MK_MIDDLE] && !m[MK_MIDDLE])
			m[MK_END] = 1'b1;
		if (last_marker[MK_END] && m[MK_MIDDLE])
			m[MK_BEGIN] = 1'b1;
		if (m[MK_BEGIN]) begin
			sweep_ctr = (sweep_ctr + 1) % SWEEP_SLOTS;
			r.sweep_el = pos_ring[p].tgt_el;
			r.sweep_az = pos_ring[p].tgt_az;
			sweep_begins++;
		end
		r.marker = m;
		r.sweep_num = 3'(sweep_ctr);
		last_marker = m;
		due_tags.push_back(r);
	endtask

	// drive one request and wait until it is taken
	task automatic send_request(input bit o, input logic [47:0] st, input logic [15:0] az, el,
		input logic [15:0] ar, er, ra, re, input logic [6:0] fl, input logic [15:0] te, ta);
		int gap;
		if ($urandom_range(99) < idle_in_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		stamp_us <= st;
		azimuth_cdeg <= az;
		elevation_cdeg <= el;
		azimuth_rate <= ar;
		elevation_rate <= er;
		raw_azimuth <= ra;
		raw_elevation <= re;
		flags <= fl;
		target_elevation <= te;
		target_azimuth <= ta;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		if (o)
			compute_pulse_tag(st);
		else
			store_position(st, az, el, ar, er, ra, re, fl, te, ta);
	endtask

	task automatic put_sample(input logic [47:0] st, input logic [15:0] az, el,
		input logic [6:0] fl);
		send_request(1'b0, st, az, el, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), fl, 16'($urandom_range(0, 35999)), 16'($urandom_range(0, 35999)));
	endtask

	task automatic put_pulse(input logic [47:0] st);
		send_request(1'b1, st, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// compare each taken result with the oldest pending tag
	always @(posedge clk) begin
		pulse_tag_t w;
		if (out_valid && !out_stall) begin
			if (due_tags.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				w = due_tags.pop_front();
				if (status !== w.status) report_mismatch("status", status, w.status);
				if (pulse_azimuth !== w.az) report_mismatch("azimuth", pulse_azimuth, w.az);
				if (pulse_elevation !== w.el)
					report_mismatch("elevation", pulse_elevation, w.el);
				if (pulse_az_rate !== w.az_rate)
					report_mismatch("az rate", pulse_az_rate, w.az_rate);
				if (pulse_el_rate !== w.el_rate)
					report_mismatch("el rate", pulse_el_rate, w.el_rate);
				if (pulse_raw_az !== w.raw_az) report_mismatch("raw az", pulse_raw_az, w.raw_az);
				if (pulse_raw_el !== w.raw_el) report_mismatch("raw el", pulse_raw_el, w.raw_el);
				if (marker !== w.marker) report_mismatch("marker", marker, w.marker);
				if (sweep_number !== w.sweep_num)
					report_mismatch("sweep number", sweep_number, w.sweep_num);
				if (sweep_elevation !== w.sweep_el)
					report_mismatch("sweep elevation", sweep_elevation, w.sweep_el);
				if (sweep_azimuth !== w.sweep_az)
					report_mismatch("sweep azimuth", sweep_azimuth, w.sweep_az);
			end
		end
	end

	// watchdog on cycles with no request or result taken
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results pending", due_tags.size());
			$display("Verification failed");
			$finish;
		end
	end

	// extremes, wraps, empty ring and degenerate time pairs
	task automatic test_edges();
		put_pulse(48'd0);
		send_request(1'b0, 48'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF,
			7'h00, 16'd0, 16'd0);
		put_pulse(48'd0);
		send_request(1'b0, 48'd1000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
			16'd0, 7'h7F, 16'hFFFF, 16'hFFFF);
		put_pulse(48'd0);
		put_pulse(48'd500);
		put_pulse(48'd999);
		put_pulse(48'd1000);
		put_sample(48'd2000, 16'd35900, 16'd35999, 7'h15);
		put_sample(48'd3000, 16'd100, 16'd0, 7'h15);
		put_pulse(48'd2500);
		put_pulse(48'd2999);
		put_sample(48'd3000, 16'd200, 16'd18000, 7'h1D);
		put_sample(48'd2900, 16'd18000, 16'd0, 7'h23);
		put_pulse(48'd2950);
		put_sample(48'd4000, 16'd0, 16'd0, 7'h63);
		put_sample(48'd5000, 16'd0, 16'd0, 7'h13);
		put_pulse(48'd4500);
		put_sample(48'hFFFF_FFFF_FFFE, 16'd35999, 16'd35999, 7'h00);
		put_sample(48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 7'h01);
		put_pulse(48'hFFFF_FFFF_FFFE);
		put_pulse(48'hFFFF_FFFF_FFFF);
	endtask

	// well-formed scans: active runs of rising samples with pulses between them
	task automatic test_scan_sequences(input int n_items);
		int sent;
		int mode;
		int len;
		int np;
		logic [6:0] base;
		logic [6:0] fl;
		logic [15:0] az;
		logic [15:0] el;
		longint unsigned t;
		sent = 0;
		az = 16'($urandom_range(0, 35999));
		el = 16'($urandom_range(0, 35999));
		now_us = {$urandom_range(0, 32'h7FFF), $urandom} & 48'h7FFF_FFFF_FFFF;
		prev_us = now_us;
		while (sent < n_items) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0: base = 7'h15;
				1: base = 7'h23;
				2: base = 7'h13;
				default: base = 7'($urandom);
			endcase
			len = $urandom_range(3, 12);
			for (int i = 0; i < len + 3; i++) begin
				if (i >= len)
					fl = ($urandom_range(3) == 0) ? 7'($urandom) : 7'h00;
				else if (i == len - 1)
					fl = base | (($urandom_range(1)) ? 7'h08 : 7'h40);
				else
					fl = base;
				if ($urandom_range(15) == 0) begin
					az = 16'($urandom);
					el = 16'($urandom);
				end else begin
					az = 16'((32'(az) % 36000 + $urandom_range(0, 600)) % 36000);
					el = 16'((32'(el) % 36000 + $urandom_range(0, 300)) % 36000);
				end
				prev_us = now_us;
				now_us = now_us + $urandom_range(1, 2000);
				put_sample(48'(now_us), az, el, fl);
				sent++;
				np = $urandom_range(0, 3);
				for (int k = 0; k < np; k++) begin
					if ($urandom_range(19) == 0)
						t = now_us;
					else
						t = prev_us + $urandom_range(0, 32'(now_us - prev_us - 1));
					put_pulse(48'(t));
					sent++;
				end
			end
		end
	endtask

	// unordered samples and pulses, including pulses past all stored data
	task automatic test_noise(input int n_items);
		logic [47:0] st;
		for (int i = 0; i < n_items; i++) begin
			st = {16'($urandom), $urandom};
			if ($urandom_range(1))
				send_request(1'b0, st, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom),
					16'($urandom), 16'($urandom));
			else
				put_pulse(st);
		end
	endtask

	initial begin
		ring_wr = 0;
		ring_fill = 0;
		search_at = 0;
		last_marker = MK_RESET;
		sweep_ctr = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_in_pct = 24;
		stall_out_pct = 60;
		test_edges();
		test_scan_sequences(400);
		idle_in_pct = 60;
		stall_out_pct = 24;
		test_scan_sequences(400);
		test_noise(150);
		idle_in_pct = 0;
		stall_out_pct = 0;
		test_scan_sequences(300);
		test_noise(150);
		in_valid <= 1'b0;

		while (due_tags.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_tags.size() != 0)
			report_mismatch("results missing", 0, due_tags.size());

		$display("covered %0d pulses (%0d without position) and %0d sweep begins",
			pulses_seen, lost_pulses, sweep_begins);
		$display("%0d mismatches over three sender and receiver idling phases", mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
design/ppt_pkg.sv
design/ppt_ram.sv
design/pulse_position_tagger_core.sv
design/ppt_checker.sv
bench/pulse_position_tagger_core_tb.sv
